FILE: src/gpd_pkg.sv
`default_nettype none

package gpd_pkg;

   // Field width of the operands and results on the ports.
   localparam int GPD_DATA_BITS = 64;

   // Default polynomial width handled by the cell row.
   localparam int GPD_WIDTH = 64;

   // Input transfer: dividend and divisor polynomials.
   typedef struct packed {
      logic [GPD_DATA_BITS-1:0] dividend;
      logic [GPD_DATA_BITS-1:0] divisor;
   } req_payload_type;

   // Result transfer: quotient, remainder and the zero divisor flag.
   typedef struct packed {
      logic [GPD_DATA_BITS-1:0] quotient;
      logic [GPD_DATA_BITS-1:0] remainder;
      logic                     divide_by_zero;
   } rsp_payload_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic load;  // take new operand bits
      logic norm;  // shift the divisor one place toward the top
      logic step;  // one division step: conditional XOR, then shift down
      logic hit;   // the remainder bit under the divisor's leading one is set
   } gpd_ctrl_type;

endpackage

`default_nettype wire

FILE: src/gf2_polynomial_divider.sv
`default_nettype none

// Carry-less (GF(2)) polynomial divider.
// An item is transferred in at a rising edge with start high and busy low;
// req_data carries the dividend and divisor, of which the low WIDTH bits are used.
// The result shows on rsp_data for exactly one cycle, marked by rsp_strobe, and
// the receiver has no way to hold it off; it must take it in that cycle.
// After the accepting edge the row first shifts the divisor up until its leading one
// sits in the top cell; then each cycle of the division phase retires one quotient
// bit, and last comes the result cycle.
// A zero divisor gives its result (flag set, quotient zero, remainder equal to
// the dividend) in the cycle right after the accepting edge.
// busy is low again in the result cycle, so the next item may be taken at the
// edge that ends it; no new item is taken while one is in progress.
// The single row of WIDTH cells moves the divisor one place per cycle, up until
// its leading one is in the top cell, then down in the division phase.
// Reset clears the sequencer to idle and drops any item in progress; no result
// is given for it.

module gf2_polynomial_divider
   import gpd_pkg::*;
#(
   parameter int WIDTH = GPD_WIDTH
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire req_payload_type req_data,
   output logic                 rsp_strobe,
   output rsp_payload_type      rsp_data
);

   localparam int CNT_BITS = $clog2(WIDTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_NORM = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0]     q_ff, q_in;
   logic                 dbz_ff, dbz_in;

   logic [WIDTH-1:0]     r_vec, d_vec, m_vec;
   logic [WIDTH-1:0]     d_lo_vec, d_hi_vec, m_hi_vec;
   logic [WIDTH-1:0]     load_r_vec, load_d_vec, load_m_vec;
   logic                 accept;
   logic                 den_zero;
   gpd_ctrl_type         ctrl;

   // Operand bits for the cell row and the neighbor connections.
   assign load_r_vec = req_data.dividend[WIDTH-1:0];
   assign load_d_vec = req_data.divisor[WIDTH-1:0];
   assign load_m_vec = {1'b1, {(WIDTH-1){1'b0}}};
   assign d_lo_vec   = {d_vec[WIDTH-2:0], 1'b0};
   assign d_hi_vec   = {1'b0, d_vec[WIDTH-1:1]};
   assign m_hi_vec   = {1'b0, m_vec[WIDTH-1:1]};
   assign den_zero   = (load_d_vec == '0);

   assign busy   = ~(state_ff == ST_IDLE || state_ff == ST_DONE);
   assign accept = start & ~busy;

   // The row of cells.
   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      gpd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_r    (load_r_vec[i]),
         .load_d    (load_d_vec[i]),
         .load_m    (load_m_vec[i]),
         .d_from_lo (d_lo_vec[i]),
         .d_from_hi (d_hi_vec[i]),
         .m_from_hi (m_hi_vec[i]),
         .r_out     (r_vec[i]),
         .d_out     (d_vec[i]),
         .m_out     (m_vec[i])
      );
   end

   // Sequencer: normalize the divisor, then retire one quotient bit per cycle.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      dbz_in    = dbz_ff;
      ctrl.load = 1'b0;
      ctrl.norm = 1'b0;
      ctrl.step = 1'b0;
      ctrl.hit  = |(r_vec & m_vec);
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            state_in = ST_IDLE;
            if (accept) begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               q_in      = '0;
               dbz_in    = den_zero;
               state_in  = den_zero ? ST_DONE : ST_NORM;
            end
         end
         ST_NORM: begin
            if (d_vec[WIDTH-1]) begin
               state_in = ST_DIV;
            end else begin
               ctrl.norm = 1'b1;
               cnt_in    = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            q_in      = {q_ff[WIDTH-2:0], ctrl.hit};
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      dbz_ff <= dbz_in;
   end

   // Result transfer, widened to the port width.
   always_comb begin
      rsp_data                     = '0;
      rsp_data.quotient[WIDTH-1:0]  = q_ff;
      rsp_data.remainder[WIDTH-1:0] = r_vec;
      rsp_data.divide_by_zero      = dbz_ff;
   end

   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

`default_nettype wire

FILE: src/gpd_cell.sv
`default_nettype none

module gpd_cell
   import gpd_pkg::*;
(
   input  wire logic         clock,
   input  wire gpd_ctrl_type ctrl,
   input  wire logic         load_r,
   input  wire logic         load_d,
   input  wire logic         load_m,
   input  wire logic         d_from_lo,
   input  wire logic         d_from_hi,
   input  wire logic         m_from_hi,
   output logic              r_out,
   output logic              d_out,
   output logic              m_out
);

   // One bit each of the remainder, the aligned divisor and the alignment marker.
   logic r_ff, r_in;
   logic d_ff, d_in;
   logic m_ff, m_in;

   // Next-state logic of the cell.
   always_comb begin
      r_in = r_ff;
      d_in = d_ff;
      m_in = m_ff;
      if (ctrl.load) begin
         r_in = load_r;
         d_in = load_d;
         m_in = load_m;
      end else if (ctrl.norm) begin
         d_in = d_from_lo;
      end else if (ctrl.step) begin
         r_in = r_ff ^ (ctrl.hit & d_ff);
         d_in = d_from_hi;
         m_in = m_from_hi;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      d_ff <= d_in;
      m_ff <= m_in;
   end

   assign r_out = r_ff;
   assign d_out = d_ff;
   assign m_out = m_ff;

endmodule

`default_nettype wire

FILE: src/gpd_checker.sv
`default_nettype none

module gpd_checker
   import gpd_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            start,
   input wire logic            busy,
   input wire rsp_payload_type rsp_data,
   input wire logic            rsp_strobe
);

   // A result is shown only once the block is free to take the next item.
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted item either keeps the block working or yields its result next.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted item neither in progress nor finished");

   // Work ends only by presenting a result.
   a_finish_strobes: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("work ended without a result");

   // A zero divisor always gives a zero quotient.
   a_dbz_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.divide_by_zero) |-> (rsp_data.quotient == '0))
      else $error("nonzero quotient on divide by zero");

endmodule

bind gf2_polynomial_divider gpd_checker u_gpd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
